/* hdl/swm_pkg.sv */
// Shared constants, payload types and control bundle of the wildcard matcher.
`timescale 1ns / 1ps

package swm_pkg;

  // Pattern store depth and the width of a length that can reach the depth itself.
  localparam int MAX_PATTERN = 32;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  // The wildcard byte.
  localparam logic [7:0] STAR_BYTE = 8'd42;

  // Action codes of an input transaction.
  localparam logic [1:0] ACT_PATTERN = 2'd0;
  localparam logic [1:0] ACT_SUBJECT = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_in;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic at_end;
    logic pattern_overflow;
  } out_item_t;

  // Controls broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic       subj_step;
    logic       start;
    logic       empty;
    logic [7:0] char_in;
  } swm_ctl_t;

endpackage

/* hdl/swm_in_if.sv */
// Input channel interface: valid/ready handshake with an input item payload.
`timescale 1ns / 1ps

interface swm_in_if;
  logic               valid;
  logic               ready;
  swm_pkg::in_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

/* hdl/swm_out_if.sv */
// Result channel interface: valid/ready handshake with a result item payload.
`timescale 1ns / 1ps

interface swm_out_if;
  logic               valid;
  logic               ready;
  swm_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

/* hdl/swm_cell.sv */
// One pattern position: its stored byte, its active bit and its star-prefix bit.
`timescale 1ns / 1ps

module swm_cell (
  input  logic              clk,
  input  logic              rst,
  input  swm_pkg::swm_ctl_t ctl,
  input  logic              sel,
  input  logic              live,
  input  logic              sv_in,
  input  logic              carry_in,
  output logic              sv_out,
  output logic              carry_out,
  output logic              next
);

  logic [7:0] pat;
  logic       act;
  logic       sv;
  logic       is_star;
  logic       base;
  logic       gate;

  // The stored byte is a wildcard.
  assign is_star = (pat == swm_pkg::STAR_BYTE);

  // Star-prefix bit as the right neighbor sees it; a new pattern drops it at once.
  assign sv_out = ctl.empty ? 1'b0 : sv;

  // At the start of a subject the position is active when all earlier bytes are stars.
  assign base = ctl.start ? sv_in : act;
  assign gate = base & live;

  // A star keeps its position active; the left neighbor may hand activity in.
  assign next = (gate & is_star) | carry_in;

  // Hand activity to the next position on a literal hit or across a star.
  assign carry_out = (gate & ~is_star & (pat == ctl.char_in)) | (next & is_star & live);

  // Control state: active bit and star-prefix bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      sv  <= 1'b0;
    end else begin
      if (ctl.subj_step) begin
        act <= next;
      end
      if (sel) begin
        sv <= sv_in & (ctl.char_in == swm_pkg::STAR_BYTE);
      end else if (ctl.empty) begin
        sv <= 1'b0;
      end
    end
  end

  // Pattern byte, written when this cell is the append position.
  always_ff @(posedge clk) begin
    if (sel) begin
      pat <= ctl.char_in;
    end
  end

endmodule

/* hdl/swm_out_queue.sv */
// Two-entry result queue that decouples the matcher from the result channel.
`timescale 1ns / 1ps

module swm_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  swm_pkg::out_item_t push_item,
  output logic               full,
  swm_out_if.source          out_ch
);

  logic [1:0]         count;
  swm_pkg::out_item_t q0;
  logic               pop;
  swm_pkg::out_item_t q1;

  assign full         = (count == 2'd2);
  assign out_ch.valid = (count != 2'd0);
  assign out_ch.item  = q0;
  assign pop          = out_ch.valid & out_ch.ready;

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // Entry data; the head is always q0.
  always_ff @(posedge clk) begin
    if (pop) begin
      q0 <= (push && count == 2'd1) ? push_item : q1;
      if (push && count == 2'd2) begin
        q1 <= push_item;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        q0 <= push_item;
      end else begin
        q1 <= push_item;
      end
    end
  end

endmodule

/* hdl/star_wildcard_matcher.sv */
// Top level of the anchored star wildcard matcher built as a row of pattern cells.
//
//   Channel  Dir  Payload                                 Transaction
//   in_ch    in   action, char_in, last                   pattern byte, subject byte or clear
//   out_ch   out  matched, at_end, pattern_overflow       one per subject byte
//
// A new input transaction may be accepted while in_ch.ready is high; a subject byte may follow in the next cycle.
// The cycle time is set by the combinational activity chain that ripples through all cells.
// A result is registered in the result queue and is offered on out_ch once earlier results are taken.
// Two results can wait for out_ch; in_ch.ready drops only while both entries are held.
// Synchronous reset empties the pattern and the result queue; no clearing pass is needed.
`timescale 1ns / 1ps

module star_wildcard_matcher (
  input  logic      clk,
  input  logic      rst,
  swm_in_if.sink    in_ch,
  swm_out_if.source out_ch
);

  localparam int MP = swm_pkg::MAX_PATTERN;
  localparam int LW = swm_pkg::LEN_W;

  logic [LW-1:0]      len;
  logic [LW-1:0]      len_next;
  logic [LW-1:0]      len_eff;
  logic               ovf;
  logic               ovf_next;
  logic               subj_start;
  logic               pat_start;
  logic               acc;
  logic               is_pat;
  logic               is_subj;
  logic               is_clr;
  logic               append;
  logic               q_full;
  swm_pkg::swm_ctl_t  ctl;
  swm_pkg::out_item_t res;
  logic [MP-1:0]      sel;
  logic [MP-1:0]      live;
  logic [MP-1:0]      sv_chain;
  logic [MP:0]        carry;
  logic [MP:0]        nxt;

  // Decode the accepted transaction.
  assign acc     = in_ch.valid & in_ch.ready;
  assign is_pat  = acc & (in_ch.item.action == swm_pkg::ACT_PATTERN);
  assign is_subj = acc & (in_ch.item.action == swm_pkg::ACT_SUBJECT);
  assign is_clr  = acc & (in_ch.item.action == swm_pkg::ACT_CLEAR);

  // A pattern byte that opens a new pattern appends at position zero.
  assign len_eff = pat_start ? '0 : len;
  assign append  = is_pat & (len_eff != LW'(MP));

  assign ctl.subj_step = is_subj;
  assign ctl.start     = subj_start;
  assign ctl.empty     = is_clr | (is_pat & pat_start);
  assign ctl.char_in   = in_ch.item.char_in;

  // Pattern length and overflow flag updates.
  always_comb begin
    len_next = len;
    ovf_next = ovf;
    if (is_clr) begin
      len_next = '0;
      ovf_next = 1'b0;
    end else if (is_pat) begin
      if (append) begin
        len_next = len_eff + LW'(1);
        ovf_next = pat_start ? 1'b0 : ovf;
      end else begin
        len_next = len_eff;
        ovf_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len        <= '0;
      ovf        <= 1'b0;
      pat_start  <= 1'b1;
      subj_start <= 1'b1;
    end else begin
      len <= len_next;
      ovf <= ovf_next;
      if (is_pat) begin
        pat_start  <= in_ch.item.last;
        subj_start <= 1'b1;
      end else if (is_clr) begin
        pat_start  <= 1'b1;
        subj_start <= 1'b1;
      end else if (is_subj) begin
        subj_start <= in_ch.item.last;
      end
    end
  end

  // Row of cells; position zero always starts active, no activity enters from the left.
  assign carry[0] = 1'b0;
  assign sv_chain[0] = 1'b1;

  for (genvar j = 0; j < MP; j++) begin : g_cell
    assign sel[j]  = append & (len_eff == LW'(j));
    assign live[j] = (len > LW'(j));
    if (j + 1 < MP) begin : g_mid
      swm_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .sel       (sel[j]),
        .live      (live[j]),
        .sv_in     (sv_chain[j]),
        .carry_in  (carry[j]),
        .sv_out    (sv_chain[j+1]),
        .carry_out (carry[j+1]),
        .next      (nxt[j])
      );
    end else begin : g_end
      swm_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .sel       (sel[j]),
        .live      (live[j]),
        .sv_in     (sv_chain[j]),
        .carry_in  (carry[j]),
        .sv_out    (),
        .carry_out (carry[j+1]),
        .next      (nxt[j])
      );
    end
  end

  // The position past the last cell is fed only by the end of the chain.
  assign nxt[MP] = carry[MP];

  // Result of a subject byte: the whole pattern is consumed.
  assign res.matched          = nxt[len] & ~ovf;
  assign res.at_end           = in_ch.item.last;
  assign res.pattern_overflow = ovf;

  swm_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (is_subj),
    .push_item (res),
    .full      (q_full),
    .out_ch    (out_ch)
  );

  assign in_ch.ready = ~q_full;

`ifndef SYNTHESIS
  // The length never exceeds the store.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(MP))
    else $error("pattern length beyond store depth");

  // Overflow is only possible with a full store.
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (len == LW'(MP)))
    else $error("overflow flag set without a full pattern store");

  // A subject transaction always leaves a result waiting in the next cycle.
  a_subj_result: assert property (@(posedge clk) disable iff (rst)
    is_subj |=> out_ch.valid)
    else $error("subject byte produced no result");

  // Back-pressure on the input only happens while results are waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with an empty result queue");
`endif

endmodule

/* dv/tb_star_wildcard_matcher.sv */
// Self-checking testbench of the star wildcard matcher: directed table, back-pressure, random.
`timescale 1ns / 1ps

module tb_star_wildcard_matcher;

  // Action code that the block ignores.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 48;
  localparam int STUCK_LIMIT  = 1000;

  // Active-position vector with only the start position set.
  localparam logic [swm_pkg::MAX_PATTERN:0] START_ONLY = {{swm_pkg::MAX_PATTERN{1'b0}}, 1'b1};

  // Verdicts that can be read off directly.
  localparam swm_pkg::out_item_t NO_MATCH_END =
    '{matched: 1'b0, at_end: 1'b1, pattern_overflow: 1'b0};
  localparam swm_pkg::out_item_t MATCH_END    =
    '{matched: 1'b1, at_end: 1'b1, pattern_overflow: 1'b0};

  typedef struct {
    swm_pkg::in_item_t  item;
    bit                 typed;
    swm_pkg::out_item_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  swm_in_if  in_ch ();
  swm_out_if out_ch ();

  star_wildcard_matcher u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state of the matcher.
  logic [7:0]                    pat_bytes [swm_pkg::MAX_PATTERN];
  int                            pat_len  = 0;
  logic [swm_pkg::MAX_PATTERN:0] live_pos = '0;
  bit                            subj_new = 1'b1;
  bit                            pat_new  = 1'b1;
  bit                            pat_ovf  = 1'b0;

  swm_pkg::out_item_t pending_verdicts [$];
  dir_row_t           dir_rows [$];
  logic [7:0]         gen_pat [$];

  int mismatches    = 0;
  int counted_items = 0;
  int results_seen  = 0;
  int matches_seen  = 0;
  int overflow_seen = 0;
  int stuck_cycles  = 0;
  bit no_idle       = 1'b0;
  bit hold_out      = 1'b0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Extend an active-position vector across stars, from low to high positions.
  function automatic logic [swm_pkg::MAX_PATTERN:0] star_closure(
      input logic [swm_pkg::MAX_PATTERN:0] v);
    for (int j = 0; j < pat_len; j++) begin
      if (v[j] && pat_bytes[j] == swm_pkg::STAR_BYTE) v[j + 1] = 1'b1;
    end
    return v;
  endfunction

  // Apply one input transaction to the predictor; returns 1 when it yields a verdict.
  function automatic bit advance_matcher(input swm_pkg::in_item_t it,
                                         output swm_pkg::out_item_t verdict);
    logic [swm_pkg::MAX_PATTERN:0] nxt;
    bit                            produced;
    produced = 1'b0;
    verdict  = '0;
    case (it.action)
      swm_pkg::ACT_PATTERN: begin
        if (pat_new) begin
          pat_len = 0;
          pat_ovf = 1'b0;
        end
        if (pat_len < swm_pkg::MAX_PATTERN) begin
          pat_bytes[pat_len] = it.char_in;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
        pat_new  = it.last;
        subj_new = 1'b1;
      end
      swm_pkg::ACT_CLEAR: begin
        pat_len  = 0;
        pat_ovf  = 1'b0;
        pat_new  = 1'b1;
        subj_new = 1'b1;
      end
      swm_pkg::ACT_SUBJECT: begin
        if (subj_new) live_pos = star_closure(START_ONLY);
        nxt = '0;
        for (int j = 0; j < pat_len; j++) begin
          if (live_pos[j]) begin
            if (pat_bytes[j] == swm_pkg::STAR_BYTE) nxt[j] = 1'b1;
            else if (pat_bytes[j] == it.char_in) nxt[j + 1] = 1'b1;
          end
        end
        live_pos = star_closure(nxt);
        subj_new = it.last;
        verdict.matched          = live_pos[pat_len] && !pat_ovf;
        verdict.at_end           = it.last;
        verdict.pattern_overflow = pat_ovf;
        produced = 1'b1;
      end
      default: begin
      end
    endcase
    return produced;
  endfunction

  // Print one mismatch line and count it.
  task automatic report(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic void add_row(input logic [1:0] act, input logic [7:0] ch,
                                  input logic lst, input bit typed = 1'b0,
                                  input swm_pkg::out_item_t want = '0);
    dir_row_t r;
    r.item.action  = act;
    r.item.char_in = ch;
    r.item.last    = lst;
    r.typed        = typed;
    r.want         = want;
    dir_rows.push_back(r);
  endfunction

  // Offer one input transaction after a random gap and predict it once accepted.
  task automatic send_item(input swm_pkg::in_item_t it, input bit typed = 1'b0,
                           input swm_pkg::out_item_t want = '0);
    int                 gap;
    swm_pkg::out_item_t verdict;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (it.action != ACT_UNUSED) counted_items++;
    if (advance_matcher(it, verdict)) pending_verdicts.push_back(typed ? want : verdict);
  endtask

  task automatic put(input logic [1:0] act, input logic [7:0] ch, input logic lst);
    swm_pkg::in_item_t it;
    it.action  = act;
    it.char_in = ch;
    it.last    = lst;
    send_item(it);
  endtask

  // Drop valid before the sender pauses, so no transaction is offered twice.
  task automatic idle_sender();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_letter();
    return 8'h61 + 8'($urandom_range(0, 2));
  endfunction

  // Mostly a small alphabet so that matches are common, with stars and arbitrary bytes.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return pick_letter();
    if (r < 17) return swm_pkg::STAR_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(swm_pkg::MAX_PATTERN + 1, swm_pkg::MAX_PATTERN + 8);
    if (r == 1) return $urandom_range(swm_pkg::MAX_PATTERN - 8, swm_pkg::MAX_PATTERN);
    return $urandom_range(1, 6);
  endfunction

  // Load pattern bytes, starting a fresh copy or appending to the one in progress.
  task automatic load_pattern(input int len, input bit close, input bit fresh);
    logic [7:0] b;
    if (fresh) gen_pat.delete();
    for (int i = 0; i < len; i++) begin
      b = pick_byte();
      gen_pat.push_back(b);
      put(swm_pkg::ACT_PATTERN, b, close && (i == len - 1));
    end
  endtask

  // Derive a subject from the pattern by expanding stars, then maybe corrupt one byte.
  task automatic send_subject(input bit finish);
    logic [7:0] subj [$];
    foreach (gen_pat[i]) begin
      if (gen_pat[i] == swm_pkg::STAR_BYTE) begin
        repeat ($urandom_range(0, 2)) subj.push_back(pick_letter());
      end else begin
        subj.push_back(gen_pat[i]);
      end
    end
    if (subj.size() > 0 && $urandom_range(0, 2) == 0)
      subj[$urandom_range(0, subj.size() - 1)] = pick_byte();
    if (subj.size() == 0) subj.push_back(pick_byte());
    foreach (subj[i])
      put(swm_pkg::ACT_SUBJECT, subj[i], finish && (i == subj.size() - 1));
  endtask

  // Compare each accepted result with the oldest pending verdict.
  always @(posedge clk) begin : check_results
    swm_pkg::out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.item.matched) matches_seen++;
      if (out_ch.item.pattern_overflow) overflow_seen++;
      if (pending_verdicts.size() == 0) begin
        report("result with no verdict pending", 1, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_ch.item.matched !== want.matched)
          report("matched", out_ch.item.matched, want.matched);
        if (out_ch.item.at_end !== want.at_end)
          report("at_end", out_ch.item.at_end, want.at_end);
        if (out_ch.item.pattern_overflow !== want.pattern_overflow)
          report("pattern_overflow", out_ch.item.pattern_overflow, want.pattern_overflow);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d verdicts pending",
               STUCK_LIMIT, pending_verdicts.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Result receiver: random stalls per result, plus one long hold on request.
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_out) begin
        stall    = HOLD_CYCLES;
        hold_out = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  // Main stimulus.
  initial begin : stimulus
    int mode;
    int len;
    int seq;
    int start_count;
    rst         = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.item  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty pattern right after reset: a subject byte never matches.
    add_row(swm_pkg::ACT_SUBJECT, "a", 1'b1, 1'b1, NO_MATCH_END);
    // The unused action is ignored.
    add_row(ACT_UNUSED, 8'hFF, 1'b1);
    // Leading star against a subject that needs more than one restart point.
    add_row(swm_pkg::ACT_PATTERN, swm_pkg::STAR_BYTE, 1'b0);
    add_row(swm_pkg::ACT_PATTERN, "a", 1'b0);
    add_row(swm_pkg::ACT_PATTERN, "b", 1'b1);
    add_row(swm_pkg::ACT_SUBJECT, "a", 1'b0);
    add_row(swm_pkg::ACT_SUBJECT, "a", 1'b0);
    add_row(swm_pkg::ACT_SUBJECT, "b", 1'b1);
    // All-ones byte as a one-byte pattern and subject.
    add_row(swm_pkg::ACT_PATTERN, 8'hFF, 1'b1);
    add_row(swm_pkg::ACT_SUBJECT, 8'hFF, 1'b1, 1'b1, MATCH_END);
    // Subject during a pattern load; the load then resumes and interrupts it.
    add_row(swm_pkg::ACT_PATTERN, 8'h00, 1'b0);
    add_row(swm_pkg::ACT_SUBJECT, 8'h00, 1'b0);
    add_row(swm_pkg::ACT_PATTERN, swm_pkg::STAR_BYTE, 1'b1);
    add_row(swm_pkg::ACT_SUBJECT, 8'h01, 1'b0);
    add_row(swm_pkg::ACT_SUBJECT, 8'h00, 1'b1);
    // Clear leaves an empty pattern that matches no subject byte.
    add_row(swm_pkg::ACT_CLEAR, 8'h00, 1'b0);
    add_row(swm_pkg::ACT_SUBJECT, "a", 1'b1, 1'b1, NO_MATCH_END);
    // Trailing stars match any subject.
    add_row(swm_pkg::ACT_PATTERN, swm_pkg::STAR_BYTE, 1'b0);
    add_row(swm_pkg::ACT_PATTERN, swm_pkg::STAR_BYTE, 1'b1);
    add_row(swm_pkg::ACT_SUBJECT, 8'h00, 1'b1, 1'b1, MATCH_END);
    // A pattern byte abandons the subject in progress.
    add_row(swm_pkg::ACT_SUBJECT, "x", 1'b0);
    add_row(swm_pkg::ACT_PATTERN, "q", 1'b1);
    add_row(swm_pkg::ACT_SUBJECT, "q", 1'b1, 1'b1, MATCH_END);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // Back-pressure: a lone star matches every byte while the receiver holds off.
    put(swm_pkg::ACT_PATTERN, swm_pkg::STAR_BYTE, 1'b1);
    no_idle  = 1'b1;
    hold_out = 1'b1;
    repeat (12) put(swm_pkg::ACT_SUBJECT, 8'($urandom_range(0, 255)), 1'b0);
    put(swm_pkg::ACT_SUBJECT, 8'($urandom_range(0, 255)), 1'b1);
    // Sender pauses until every verdict has come back.
    idle_sender();
    while (pending_verdicts.size() != 0) @(posedge clk);

    // Random sequences, mostly well formed, some broken, some noise.
    start_count = counted_items;
    seq = 0;
    while (counted_items < start_count + RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      mode    = (seq == 0) ? 9 : $urandom_range(0, 9);
      if (mode == 0) begin
        // Noise over the whole input space.
        repeat ($urandom_range(1, 6))
          put(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
      end else if (mode == 1) begin
        // Subject against a half-loaded pattern, then the load completes.
        load_pattern($urandom_range(1, 3), 1'b0, 1'b1);
        send_subject(1'b0);
        load_pattern($urandom_range(1, 3), 1'b1, 1'b0);
        send_subject(1'b1);
      end else if (mode == 2) begin
        // Subject cut off by a clear, then matched against the empty pattern.
        load_pattern($urandom_range(1, 4), 1'b1, 1'b1);
        send_subject(1'b0);
        put(swm_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        put(swm_pkg::ACT_SUBJECT, pick_byte(), 1'($urandom_range(0, 1)));
      end else begin
        // Complete pattern and a few subjects derived from it; the first overflows.
        len = (seq == 0) ? swm_pkg::MAX_PATTERN + 1 : pick_length();
        load_pattern(len, 1'b1, 1'b1);
        repeat ($urandom_range(1, 3)) send_subject($urandom_range(0, 5) != 0);
      end
      seq++;
    end

    // Drain and settle.
    idle_sender();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Run covered %0d transactions in %0d random sequences and %0d checked results.",
             counted_items, seq, results_seen);
    $display("Results that matched: %0d; results under pattern overflow: %0d.",
             matches_seen, overflow_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
